@@ hw/rtl/nls_pkg.sv @@
// ----------------------------------------------------------------------------
// nls_pkg
// Shared item types and character/kind codes for the numeric literal scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package nls_pkg;

    // character codes
    localparam logic [7:0] C_0     = 8'h30;
    localparam logic [7:0] C_7     = 8'h37;
    localparam logic [7:0] C_9     = 8'h39;
    localparam logic [7:0] C_X_LO  = 8'h78;
    localparam logic [7:0] C_X_UP  = 8'h58;
    localparam logic [7:0] C_E_LO  = 8'h65;
    localparam logic [7:0] C_E_UP  = 8'h45;
    localparam logic [7:0] C_F_LO  = 8'h66;
    localparam logic [7:0] C_F_UP  = 8'h46;
    localparam logic [7:0] C_A_LO  = 8'h61;
    localparam logic [7:0] C_A_UP  = 8'h41;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_PLUS  = 8'h2B;

    // literal kinds
    localparam logic [2:0] K_INVALID = 3'd0;
    localparam logic [2:0] K_DEC     = 3'd1;
    localparam logic [2:0] K_OCT     = 3'd2;
    localparam logic [2:0] K_HEX     = 3'd3;
    localparam logic [2:0] K_DOUBLE  = 3'd4;
    localparam logic [2:0] K_FLOAT   = 3'd5;

    // accumulator radix select
    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic [6:0]         length;
        logic signed [63:0] value;
        logic               overflow;
    } t_out_item;

endpackage

`default_nettype wire

@@ hw/rtl/numeric_literal_scanner_top.sv @@
// ----------------------------------------------------------------------------
// numeric_literal_scanner_top
// Streaming lexer for one C-style numeric literal, one character per item.
// ----------------------------------------------------------------------------
// usage:
//   input channel  i_in_valid / o_in_stall / i_in_item (ch, start_req, last)
//   output channel o_out_valid / i_out_stall / o_out_item
//     (kind, length, value, overflow)
//   an item moves on a rising edge with valid high and stall low
//   an item with start_req opens a new token and drops any unfinished one
//   a token ends on the first rejected character, on an f suffix or on a
//   taken character marked last; each end gives exactly one result item
// result path: the ending character is accepted into the input register,
//   then one combinational step leads into the result register
// throughput: 1 character per cycle while the output is not stalled; the state
//   step and the radix multiply-add (shift-and-add in nls_mac) are combinational
// stall: while a result waits under i_out_stall the core holds its step and
//   the input register fills, then o_in_stall rises; nothing is dropped
// reset: synchronous active-low i_rst_n; scanner idle, both registers empty
// ----------------------------------------------------------------------------
`default_nettype none

module numeric_literal_scanner_top
    import nls_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  wire t_in_item i_in_item,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_item
);

    logic      in_valid;
    t_in_item  in_item;
    logic      step;
    logic      res_valid;
    t_out_item res;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      out_free;

    // result register empty or draining this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    // core steps on the buffered character only when a result can be stored
    assign step     = in_valid && out_free;

    nls_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (step),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    nls_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (step),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // stall toward the sender only while a character is buffered
    a_stall_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> in_valid)
        else $error("input stall without a buffered item");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.kind <= K_FLOAT))
        else $error("result kind out of range");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.length <= 7'(MAX_LEN)))
        else $error("result length above saturation limit");

    a_nonint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind == K_INVALID || o_out_item.kind == K_DOUBLE
            || o_out_item.kind == K_FLOAT))
        |-> (o_out_item.value == '0 && !o_out_item.overflow))
        else $error("non-integer result carries value or overflow");

    // a step with a full, stalled result register would lose an item
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out_item))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/nls_in_stage.sv @@
// ----------------------------------------------------------------------------
// nls_in_stage
// Input register; holds one character item until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_in_stage
    import nls_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_stall,
    input  wire t_in_item i_item,
    input  wire       i_take,
    output logic      o_valid,
    output t_in_item  o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // full and not drained this cycle
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ hw/rtl/nls_mac.sv @@
// ----------------------------------------------------------------------------
// nls_mac
// Multiply-by-radix and add-digit step with 64-bit wrap detection.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_mac
    import nls_pkg::*;
(
    input  wire [63:0] i_acc,
    input  wire [1:0]  i_base,
    input  wire [3:0]  i_digit,
    output logic [63:0] o_sum,
    output logic        o_wrap
);

    logic [67:0] prod;
    logic [67:0] sum;

    always_comb begin
        unique case (i_base)
            BASE_OCT: prod = {1'b0, i_acc, 3'b000};
            BASE_HEX: prod = {i_acc, 4'b0000};
            BASE_DEC: prod = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0};
            default:  prod = {4'b0000, i_acc};
        endcase
        sum = prod + {64'd0, i_digit};
    end

    assign o_sum  = sum[63:0];
    assign o_wrap = |sum[67:64];

endmodule

`default_nettype wire

@@ hw/rtl/nls_core.sv @@
// ----------------------------------------------------------------------------
// nls_core
// Token state machine: one character step per enabled cycle, result on end.
// ----------------------------------------------------------------------------
`default_nettype none

module nls_core
    import nls_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_en,
    input  wire t_in_item i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);

    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_FIRST  = 10'b00_0000_0010,
        PH_SIGNED = 10'b00_0000_0100,
        PH_INT    = 10'b00_0000_1000,
        PH_FRAC   = 10'b00_0001_0000,
        PH_ESIGN  = 10'b00_0010_0000,
        PH_EXP    = 10'b00_0100_0000,
        PH_OCTHEX = 10'b00_1000_0000,
        PH_OCT    = 10'b01_0000_0000,
        PH_HEX    = 10'b10_0000_0000
    } t_phase;

    localparam logic [6:0] LP_MAX = 7'(MAX_LEN);

    t_phase      r_phase, ph, n_phase;
    logic        r_neg, neg, n_neg;
    logic [63:0] r_acc, acc, n_acc;
    logic [6:0]  r_cnt, cnt, n_cnt;
    logic [2:0]  r_kind, knd, n_kind;
    logic        r_wrap, wrp, n_wrap;

    logic [7:0]  ch;
    logic        is_dig, is_oct, is_hlo, is_hup, is_e, is_f;
    logic [3:0]  dig, hex_val;
    logic        take, done, emit, mac_en, ld_first, clr_acc, is_int;
    logic [1:0]  base;
    logic [3:0]  mac_digit;
    logic [63:0] mac_sum;
    logic        mac_wrap;

    assign ch      = i_item.ch;
    assign is_dig  = (ch >= C_0) && (ch <= C_9);
    assign is_oct  = (ch >= C_0) && (ch <= C_7);
    assign is_hlo  = (ch >= C_A_LO) && (ch <= C_F_LO);
    assign is_hup  = (ch >= C_A_UP) && (ch <= C_F_UP);
    assign is_e    = (ch == C_E_LO) || (ch == C_E_UP);
    assign is_f    = (ch == C_F_LO) || (ch == C_F_UP);
    assign dig     = ch[3:0];
    // letters a-f / A-F have low nibble 1..6
    assign hex_val = is_dig ? ch[3:0] : ch[3:0] + 4'd9;

    assign mac_digit = (base == BASE_HEX) ? hex_val : dig;

    nls_mac u_mac (
        .i_acc   (acc),
        .i_base  (base),
        .i_digit (mac_digit),
        .o_sum   (mac_sum),
        .o_wrap  (mac_wrap)
    );

    always_comb begin
        // start clears the token context
        if (i_item.start_req) begin
            ph  = PH_FIRST;
            neg = 1'b0;
            acc = '0;
            cnt = '0;
            knd = K_INVALID;
            wrp = 1'b0;
        end else begin
            ph  = r_phase;
            neg = r_neg;
            acc = r_acc;
            cnt = r_cnt;
            knd = r_kind;
            wrp = r_wrap;
        end

        n_phase  = ph;
        n_neg    = neg;
        n_kind   = knd;
        take     = 1'b0;
        done     = 1'b0;
        mac_en   = 1'b0;
        ld_first = 1'b0;
        clr_acc  = 1'b0;
        base     = BASE_DEC;

        unique case (ph)
            PH_IDLE: begin
            end
            PH_FIRST: begin
                if (ch == C_MINUS || ch == C_PLUS) begin
                    n_neg   = (ch == C_MINUS);
                    n_phase = PH_SIGNED;
                    take    = 1'b1;
                end else if (is_dig) begin
                    ld_first = 1'b1;
                    take     = 1'b1;
                end
            end
            PH_SIGNED: begin
                if (is_dig) begin
                    ld_first = 1'b1;
                    take     = 1'b1;
                end
            end
            PH_INT: begin
                if (is_dig) begin
                    mac_en = 1'b1;
                    take   = 1'b1;
                end else if (ch == C_DOT) begin
                    n_phase = PH_FRAC;
                    n_kind  = K_DOUBLE;
                    take    = 1'b1;
                end else if (is_e) begin
                    n_phase = PH_ESIGN;
                    n_kind  = K_DOUBLE;
                    take    = 1'b1;
                end
            end
            PH_FRAC: begin
                if (is_dig) begin
                    take = 1'b1;
                end else if (is_e) begin
                    n_phase = PH_ESIGN;
                    n_kind  = K_DOUBLE;
                    take    = 1'b1;
                end
            end
            PH_ESIGN: begin
                if (ch == C_PLUS || ch == C_MINUS || is_dig) begin
                    n_phase = PH_EXP;
                    take    = 1'b1;
                end else if (is_f) begin
                    n_kind = K_FLOAT;
                    take   = 1'b1;
                    done   = 1'b1;
                end
            end
            PH_EXP: begin
                if (is_dig) begin
                    take = 1'b1;
                end else if (is_f) begin
                    n_kind = K_FLOAT;
                    take   = 1'b1;
                    done   = 1'b1;
                end
            end
            PH_OCTHEX: begin
                if (ch == C_X_LO || ch == C_X_UP) begin
                    n_phase = PH_HEX;
                    n_kind  = K_HEX;
                    clr_acc = 1'b1;
                    take    = 1'b1;
                end else if (is_oct) begin
                    n_phase = PH_OCT;
                    n_kind  = K_OCT;
                    base    = BASE_OCT;
                    mac_en  = 1'b1;
                    take    = 1'b1;
                end else if (ch == C_DOT) begin
                    n_phase = PH_FRAC;
                    n_kind  = K_DOUBLE;
                    take    = 1'b1;
                end
            end
            PH_OCT: begin
                base = BASE_OCT;
                if (is_oct) begin
                    mac_en = 1'b1;
                    take   = 1'b1;
                end
            end
            PH_HEX: begin
                base = BASE_HEX;
                if (is_dig || is_hlo || is_hup) begin
                    mac_en = 1'b1;
                    take   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // first digit: a leading zero may still turn octal or hex
        if (ld_first) begin
            n_kind  = K_DEC;
            n_phase = (ch == C_0) ? PH_OCTHEX : PH_INT;
        end

        if (ld_first) begin
            n_acc = {60'd0, dig};
        end else if (clr_acc) begin
            n_acc = '0;
        end else if (mac_en) begin
            n_acc = mac_sum;
        end else begin
            n_acc = acc;
        end
        n_wrap = wrp | (mac_en & mac_wrap);

        n_cnt = (take && (cnt < LP_MAX)) ? cnt + 7'd1 : cnt;

        emit = (ph != PH_IDLE) && (!take || done || i_item.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_kind  <= K_INVALID;
            r_wrap  <= 1'b0;
        end else if (i_en) begin
            r_phase <= emit ? PH_IDLE : n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
            r_wrap  <= n_wrap;
        end
    end

    assign is_int = (n_kind == K_DEC) || (n_kind == K_OCT) || (n_kind == K_HEX);

    always_comb begin
        o_res_valid    = i_en && emit;
        o_res.kind     = n_kind;
        o_res.length   = n_cnt;
        o_res.value    = is_int ? (n_neg ? -n_acc : n_acc) : '0;
        o_res.overflow = is_int & n_wrap;
    end

endmodule

`default_nettype wire
